// ----- rtl/alle_pkg.sv -----
// ----------------------------------------------------------------------------
// alle_pkg: shared types and codes for the linked list engine
// Operation selector codes and the sequencer state type.
// ----------------------------------------------------------------------------
package alle_pkg;

    localparam int FUNC_BITS = 3;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_APPEND = 3'd0,
        FN_DELETE = 3'd1,
        FN_SEARCH = 3'd2,
        FN_INSERT = 3'd3,
        FN_REMOVE = 3'd4,
        FN_READ   = 3'd5
    } t_func;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ALLOC = 8'b0000_0010,
        ST_FETCH = 8'b0000_0100,
        ST_WAIT  = 8'b0000_1000,
        ST_VISIT = 8'b0001_0000,
        ST_LINK  = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

endpackage

// ----- rtl/array_linked_list_engine.sv -----
// ----------------------------------------------------------------------------
// array_linked_list_engine: cursor based linked list in a fixed node store
// One operation per beat. Each node visited passes through read, wait and
// compare states (ST_FETCH, ST_WAIT, ST_VISIT). Append and insert first scan
// the used map for the lowest free slot, one slot per cycle.
// Items are taken one at a time; the result holds until taken.
// Reset clears head, count and the used map at once; node memory is not reset.
// ----------------------------------------------------------------------------
module array_linked_list_engine #(
    parameter int CAPACITY  = 128,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [alle_pkg::FUNC_BITS-1:0]    i_func,
    input  logic [KEY_BITS-1:0]               i_key,
    input  logic [DATA_BITS-1:0]              i_payload,
    input  logic [7:0]                        i_position,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_ok,
    output logic [KEY_BITS-1:0]               o_found_key,
    output logic [DATA_BITS-1:0]              o_found_payload,
    output logic [$clog2(CAPACITY+1)-1:0]     o_length,
    output logic                              o_is_empty,
    output logic                              o_is_full
);
    import alle_pkg::*;

    localparam int SB = $clog2(CAPACITY+1);   // slot code incl. end marker
    localparam int IB = $clog2(CAPACITY);
    localparam logic [SB-1:0] END_MARK = SB'(CAPACITY);

    logic [KEY_BITS-1:0]  m_key  [CAPACITY];
    logic [DATA_BITS-1:0] m_data [CAPACITY];
    logic [SB-1:0]        m_next [CAPACITY];
    logic [CAPACITY-1:0]  r_used;

    t_state r_state;
    logic [FUNC_BITS-1:0] r_func;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;
    logic [SB-1:0]        r_target;   // node count to step past
    logic [SB-1:0]        r_head, r_count, r_cur, r_prev, r_new, r_step, r_visited;
    logic [KEY_BITS-1:0]  r_rkey;
    logic [DATA_BITS-1:0] r_rdata;
    logic [SB-1:0]        r_rnext;
    logic                 r_ok, r_hit;
    logic [KEY_BITS-1:0]  r_fk;
    logic [DATA_BITS-1:0] r_fd;

    // node memory write port, driven by the sequencer
    logic                 w_en;
    logic [IB-1:0]        w_addr;
    logic                 w_full;
    logic [SB-1:0]        w_next;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_ok = r_ok;
    assign o_found_key = r_fk;
    assign o_found_payload = r_fd;
    assign o_length = r_count;
    assign o_is_empty = (r_count == '0);
    assign o_is_full = (r_count == END_MARK);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_next[w_addr] <= w_next;
            if (w_full) begin
                m_key[w_addr]  <= r_key;
                m_data[w_addr] <= r_data;
            end
        end
        r_rkey  <= m_key[r_cur[IB-1:0]];
        r_rdata <= m_data[r_cur[IB-1:0]];
        r_rnext <= m_next[r_cur[IB-1:0]];
    end

    logic is_ins;
    assign is_ins = (r_func == FN_APPEND) || (r_func == FN_INSERT);

    always_ff @(posedge i_clk) begin
        w_en <= 1'b0;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_head  <= END_MARK;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_func <= i_func; r_key <= i_key; r_data <= i_payload;
                    r_ok <= 1'b0; r_hit <= 1'b0;
                    r_fk <= '0; r_fd <= '0;
                    r_cur <= r_head; r_prev <= END_MARK;
                    r_step <= '0; r_visited <= '0; r_new <= '0;
                    r_state <= ST_DONE;
                    case (t_func'(i_func))
                        FN_APPEND: if (r_count != END_MARK) begin
                            r_target <= r_count; r_state <= ST_ALLOC;
                        end
                        FN_INSERT: if (r_count != END_MARK && i_position != 8'd0
                                && {1'b0, i_position} <= 9'(r_count) + 9'd1) begin
                            r_target <= SB'(i_position - 8'd1); r_state <= ST_ALLOC;
                        end
                        FN_DELETE, FN_SEARCH: if (r_count != '0) begin
                            r_target <= r_count; r_state <= ST_FETCH;
                        end
                        FN_REMOVE, FN_READ: if (i_position != 8'd0
                                && 9'(i_position) <= 9'(r_count)) begin
                            r_target <= SB'(i_position - 8'd1); r_state <= ST_FETCH;
                        end
                        default: r_state <= ST_OUT;
                    endcase
                end
                // Scan for the lowest free slot, one per cycle.
                ST_ALLOC: begin
                    if (!r_used[r_new[IB-1:0]]) begin
                        r_state <= ST_FETCH;
                    end else begin
                        r_new <= r_new + 1'b1;
                    end
                end
                ST_FETCH: begin
                    // Positional ops stop once r_target nodes are passed.
                    if (r_func != FN_DELETE && r_func != FN_SEARCH
                            && r_step == r_target) begin
                        r_state <= ST_LINK;
                    end else if (r_visited == r_target || r_cur == END_MARK) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: r_state <= ST_VISIT;
                ST_VISIT: begin
                    r_visited <= r_visited + 1'b1;
                    r_state <= ST_FETCH;
                    if (r_func == FN_SEARCH) begin
                        if (r_rkey == r_key) begin
                            r_ok <= 1'b1; r_fk <= r_rkey; r_fd <= r_rdata;
                            r_state <= ST_DONE;
                        end
                        r_cur <= r_rnext;
                    end else if (r_func == FN_DELETE) begin
                        if (r_rkey == r_key) begin
                            r_hit <= 1'b1;
                            if (r_prev == END_MARK) begin
                                r_head <= r_rnext;
                            end else begin
                                w_en <= 1'b1; w_full <= 1'b0;
                                w_addr <= r_prev[IB-1:0]; w_next <= r_rnext;
                            end
                            r_used[r_cur[IB-1:0]] <= 1'b0;
                            r_count <= r_count - 1'b1;
                        end else begin
                            r_prev <= r_cur;
                        end
                        r_cur <= r_rnext;
                    end else begin
                        r_step <= r_step + 1'b1;
                        r_prev <= r_cur;
                        r_cur <= r_rnext;
                    end
                end
                // r_cur is the node at the position, r_prev its predecessor.
                // The read registers already hold the node at r_cur here.
                ST_LINK: begin
                    r_ok <= 1'b1;
                    r_state <= ST_DONE;
                    if (is_ins) begin
                        w_en <= 1'b1; w_full <= 1'b1;
                        w_addr <= r_new[IB-1:0]; w_next <= r_cur;
                        r_used[r_new[IB-1:0]] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        if (r_prev == END_MARK) r_head <= r_new;
                        r_hit <= (r_prev != END_MARK);
                    end else if (r_func == FN_READ) begin
                        r_fk <= r_rkey; r_fd <= r_rdata;
                    end else begin
                        if (r_prev == END_MARK) begin
                            r_head <= r_rnext;
                        end else begin
                            w_en <= 1'b1; w_full <= 1'b0;
                            w_addr <= r_prev[IB-1:0]; w_next <= r_rnext;
                        end
                        r_used[r_cur[IB-1:0]] <= 1'b0;
                        r_count <= r_count - 1'b1;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_OUT;
                    if (r_func == FN_DELETE) r_ok <= r_hit;
                    if (is_ins && r_hit) begin
                        w_en <= 1'b1; w_full <= 1'b0;
                        w_addr <= r_prev[IB-1:0]; w_next <= r_new;
                    end
                end
                ST_OUT: if (i_ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= END_MARK) else $error("count above capacity");
    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_count == '0) |-> r_head == END_MARK)
        else $error("head set on empty list");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(r_count))
        else $error("result dropped");
endmodule

// ----- test/array_linked_list_engine_tb.sv -----
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives random and directed list operations through the valid/ready
// handshake, predicts every result with a behavioral list model and checks
// each result beat field by field in order.
// ----------------------------------------------------------------------------
class list_scoreboard;
    localparam int CAP = 128;

    // Behavioral list: an ordered queue of entries is enough to predict results.
    logic [15:0] ent_key[$];
    logic [31:0] ent_payload[$];
    logic        exp_ok[$];
    logic [15:0] exp_key[$];
    logic [31:0] exp_payload[$];
    logic [7:0]  exp_length[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function int count();
        return ent_key.size();
    endfunction

    function int pending();
        return exp_ok.size();
    endfunction

    function void note_operation(logic [2:0] fn, logic [15:0] k, logic [31:0] d,
                                 logic [7:0] pos);
        logic        ok;
        logic [15:0] fk;
        logic [31:0] fd;
        int          n;
        int          i;
        ok = 1'b0;
        fk = '0;
        fd = '0;
        n = ent_key.size();
        case (fn)
            alle_pkg::FN_APPEND: begin
                if (n < CAP) begin
                    ent_key.push_back(k);
                    ent_payload.push_back(d);
                    ok = 1'b1;
                end
            end
            alle_pkg::FN_DELETE: begin
                for (i = n - 1; i >= 0; i--) begin
                    if (ent_key[i] == k) begin
                        ent_key.delete(i);
                        ent_payload.delete(i);
                        ok = 1'b1;
                    end
                end
            end
            alle_pkg::FN_SEARCH: begin
                for (i = 0; i < n; i++) begin
                    if (ent_key[i] == k) begin
                        ok = 1'b1;
                        fk = k;
                        fd = ent_payload[i];
                        break;
                    end
                end
            end
            alle_pkg::FN_INSERT: begin
                if (n < CAP && pos >= 1 && pos <= n + 1) begin
                    ent_key.insert(pos - 1, k);
                    ent_payload.insert(pos - 1, d);
                    ok = 1'b1;
                end
            end
            alle_pkg::FN_REMOVE: begin
                if (pos >= 1 && pos <= n) begin
                    ent_key.delete(pos - 1);
                    ent_payload.delete(pos - 1);
                    ok = 1'b1;
                end
            end
            alle_pkg::FN_READ: begin
                if (pos >= 1 && pos <= n) begin
                    ok = 1'b1;
                    fk = ent_key[pos - 1];
                    fd = ent_payload[pos - 1];
                end
            end
            default: ;
        endcase
        exp_ok.push_back(ok);
        exp_key.push_back(fk);
        exp_payload.push_back(fd);
        exp_length.push_back(8'(ent_key.size()));
    endfunction

    function void check_result(logic ok, logic [15:0] fk, logic [31:0] fd,
                               logic [7:0] len, logic emp, logic ful);
        logic [7:0] el;
        if (exp_ok.size() == 0) begin
            $error("result beat with no operation outstanding");
            errors++;
            return;
        end
        el = exp_length[0];
        if (ok !== exp_ok[0]) begin
            $error("ok: expected %0d, got %0d", exp_ok[0], ok);
            errors++;
        end
        if (fk !== exp_key[0]) begin
            $error("found_key: expected %0h, got %0h", exp_key[0], fk);
            errors++;
        end
        if (fd !== exp_payload[0]) begin
            $error("found_payload: expected %0h, got %0h", exp_payload[0], fd);
            errors++;
        end
        if (len !== el) begin
            $error("length: expected %0d, got %0d", el, len);
            errors++;
        end
        if (emp !== (el == 0)) begin
            $error("is_empty: expected %0d, got %0d", el == 0, emp);
            errors++;
        end
        if (ful !== (el == CAP)) begin
            $error("is_full: expected %0d, got %0d", el == CAP, ful);
            errors++;
        end
        void'(exp_ok.pop_front());
        void'(exp_key.pop_front());
        void'(exp_payload.pop_front());
        void'(exp_length.pop_front());
    endfunction
endclass

module array_linked_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [15:0] i_key = '0;
    logic [31:0] i_payload = '0;
    logic [7:0]  i_position = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_ok;
    logic [15:0] o_found_key;
    logic [31:0] o_found_payload;
    logic [7:0]  o_length;
    logic        o_is_empty;
    logic        o_is_full;

    list_scoreboard board = new();
    int          cycles = 0;
    // Fill bias: steers the random mix toward growing or shrinking the list.
    int          grow_bias = 60;

    array_linked_list_engine dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall per beat, sampled at the rising edge.
    initial begin : result_side
        int w;
        @(posedge i_rst_n);
        forever begin
            w = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w != 0) begin
                i_ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_ok, o_found_key, o_found_payload, o_length,
                               o_is_empty, o_is_full);
            @(negedge i_clk);
        end
    end

    task automatic send_op(logic [2:0] fn, logic [15:0] k, logic [31:0] d,
                           logic [7:0] pos, bit no_gap = 0);
        int w;
        w = no_gap ? 0 : $urandom_range(0, 7);
        if (w != 0) begin
            i_valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_key <= k;
        i_payload <= d;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        board.note_operation(fn, k, d, pos);
        @(negedge i_clk);
    endtask

    // Keys come from a small pool so that search and delete hit often.
    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic random_op();
        int          n;
        int          r;
        logic [7:0]  pos;
        logic [2:0]  fn;
        n = board.count();
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) pos = 8'($urandom);
        else pos = 8'($urandom_range(0, n + 1));
        if (r < grow_bias) fn = ($urandom_range(0, 1)) ? alle_pkg::FN_APPEND
                                                       : alle_pkg::FN_INSERT;
        else if (r < grow_bias + 10) fn = alle_pkg::FN_SEARCH;
        else if (r < grow_bias + 20) fn = alle_pkg::FN_READ;
        else if (r < 97) fn = ($urandom_range(0, 2) == 0) ? alle_pkg::FN_DELETE
                                                          : alle_pkg::FN_REMOVE;
        else fn = 3'($urandom_range(6, 7));
        send_op(fn, pick_key(), $urandom, pos, $urandom_range(0, 4) == 0);
    endtask

    initial begin : stimulus
        int i;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: failing paths and unused selectors, then directed ops on a short list.
        send_op(alle_pkg::FN_DELETE, 16'h0, 32'h0, 8'd1);
        send_op(alle_pkg::FN_SEARCH, 16'h0, 32'h0, 8'd1);
        send_op(alle_pkg::FN_REMOVE, 16'h0, 32'h0, 8'd1);
        send_op(alle_pkg::FN_READ, 16'h0, 32'h0, 8'd1);
        send_op(alle_pkg::FN_INSERT, 16'h1, 32'h1, 8'd0);
        send_op(3'd6, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        send_op(3'd7, 16'h0, 32'h0, 8'd0);
        send_op(alle_pkg::FN_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 8'd1);
        send_op(alle_pkg::FN_APPEND, 16'h0, 32'h0, 8'd0);
        send_op(alle_pkg::FN_APPEND, 16'h5, 32'h1234_5678, 8'd0);
        send_op(alle_pkg::FN_INSERT, 16'h5, 32'hA5A5_A5A5, 8'd4);
        send_op(alle_pkg::FN_INSERT, 16'h7, 32'h7, 8'd6);
        send_op(alle_pkg::FN_READ, 16'h0, 32'h0, 8'd4);
        send_op(alle_pkg::FN_READ, 16'h0, 32'h0, 8'd5);
        send_op(alle_pkg::FN_SEARCH, 16'h5, 32'h0, 8'd0);
        send_op(alle_pkg::FN_DELETE, 16'h5, 32'h0, 8'd0);
        send_op(alle_pkg::FN_DELETE, 16'h9, 32'h0, 8'd0);
        send_op(alle_pkg::FN_REMOVE, 16'h0, 32'h0, 8'd3);
        send_op(alle_pkg::FN_REMOVE, 16'h0, 32'h0, 8'd1);
        send_op(alle_pkg::FN_READ, 16'h0, 32'h0, 8'd1);

        // Random phases: fill to full, hold around full, drain, then mix.
        for (i = 0; i < 460; i++) begin
            if (i == 0) grow_bias = 85;
            if (board.count() == 128 && grow_bias == 85) grow_bias = 60;
            if (i == 300) grow_bias = 10;
            if (i == 400) grow_bias = 50;
            random_op();
        end

        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
